// ===== sv/tcde_pkg.sv =====
// Shared types, character codes and helper functions of the terminal cell-diff encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tcde_pkg;

    // Largest grid dimension; register values are saturated into 1..MAX_GRID_DIM.
    localparam logic [9:0] MAX_GRID_DIM = 10'd999;

    // Configuration register indexes and the width of the write data.
    localparam int unsigned CFG_W = 10;
    localparam logic [1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS = 2'd1;
    localparam logic [1:0] CFG_TRUECOLOR = 2'd2;

    // Characters of the escape sequences.
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // Code point limit and xterm palette bases.
    localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [7:0]  CUBE_BASE      = 8'd16;
    localparam logic [7:0]  GREY_BASE      = 8'd232;

    typedef logic [3:0] t_digit;

    // Three decimal digits, hundreds first.
    typedef struct packed {
        t_digit h;
        t_digit t;
        t_digit o;
    } t_dec3;

    // Hundreds digit and the remainder below one hundred.
    typedef struct packed {
        t_digit     h;
        logic [6:0] r;
    } t_hund;

    // Tens and ones digits.
    typedef struct packed {
        t_digit t;
        t_digit o;
    } t_tens;

    // One damaged cell as decided by the front end.
    typedef struct packed {
        logic        cup;
        logic        sgr;
        logic [9:0]  row1;
        logic [9:0]  col1;
        logic [23:0] fg;
        logic [23:0] bg;
        logic [4:0]  attr;
        logic [20:0] glyph;
    } t_cell;

    // One command for the byte serializer, with every number already in decimal.
    // Channel index 2 is red, 1 green, 0 blue.
    typedef struct packed {
        logic            cup;
        logic            sgr;
        logic [4:0]      attr;
        logic [20:0]     glyph;
        t_dec3           row;
        t_dec3           col;
        t_dec3 [2:0]     fg_rgb;
        t_dec3 [2:0]     bg_rgb;
        t_dec3           fg_idx;
        t_dec3           bg_idx;
    } t_cmd;

    // Level of the xterm color cube for a cube index.
    function automatic logic [7:0] cube_level(input logic [2:0] idx);
        logic [7:0] lv;
        unique case (idx)
            3'd0:    lv = 8'd0;
            3'd1:    lv = 8'd95;
            3'd2:    lv = 8'd135;
            3'd3:    lv = 8'd175;
            3'd4:    lv = 8'd215;
            default: lv = 8'd255;
        endcase
        return lv;
    endfunction

    // Nearest cube index of a channel; a tie goes to the lower level.
    function automatic logic [2:0] nearest_level(input logic [7:0] v);
        logic [2:0] idx;
        if (v < 8'd48)       idx = 3'd0;
        else if (v < 8'd116) idx = 3'd1;
        else if (v < 8'd156) idx = 3'd2;
        else if (v < 8'd196) idx = 3'd3;
        else if (v < 8'd236) idx = 3'd4;
        else                 idx = 3'd5;
        return idx;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Hundreds split of a value below one thousand, by parallel compares.
    function automatic t_hund dec_hund(input logic [9:0] v);
        t_hund res;
        logic [9:0] thr;
        res.h = '0;
        res.r = v[6:0];
        for (int k = 1; k <= 9; k++) begin
            thr = 10'(100 * k);
            if (v >= thr) begin
                res.h = t_digit'(k);
                res.r = 7'(v - thr);
            end
        end
        return res;
    endfunction

    // Tens and ones of a value below one hundred.
    function automatic t_tens dec_tens(input logic [6:0] v);
        t_tens res;
        logic [6:0] thr;
        res.t = '0;
        res.o = v[3:0];
        for (int k = 1; k <= 9; k++) begin
            thr = 7'(10 * k);
            if (v >= thr) begin
                res.t = t_digit'(k);
                res.o = 4'(v - thr);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tcde_cell_if.sv =====
// Input channel of the encoder: one front/back cell pair per beat.
// Standalone; no package needed.
`default_nettype none

interface tcde_cell_if;
    logic        valid;
    logic        ready;
    logic        frame_start;
    logic [20:0] back_glyph;
    logic [23:0] back_fg;
    logic [23:0] back_bg;
    logic [4:0]  back_attr;
    logic [20:0] front_glyph;
    logic [23:0] front_fg;
    logic [23:0] front_bg;
    logic [4:0]  front_attr;

    modport source (
        output valid, frame_start, back_glyph, back_fg, back_bg, back_attr,
        output front_glyph, front_fg, front_bg, front_attr,
        input  ready
    );
    modport sink (
        input  valid, frame_start, back_glyph, back_fg, back_bg, back_attr,
        input  front_glyph, front_fg, front_bg, front_attr,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tcde_byte_if.sv =====
// Output channel of the encoder: one byte of the terminal stream per beat.
// Standalone; no package needed.
`default_nettype none

interface tcde_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink   (input valid, out_byte, run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/tcde_front.sv =====
// Front end: accepts cell beats, tracks grid position and pen, and passes damaged cells on.
// Depends on tcde_pkg and tcde_cell_if.
`default_nettype none

module tcde_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [9:0]      i_grid_cols,
    input  logic [9:0]      i_grid_rows,
    input  logic            i_en,
    tcde_cell_if.sink       i_cell,
    output logic            o_valid,
    output tcde_pkg::t_cell o_cell
);
    import tcde_pkg::*;

    logic [9:0]  r_col, n_col;
    logic [9:0]  r_row, n_row;
    logic        r_prev_dmg, n_prev_dmg;
    logic        r_pen_valid, n_pen_valid;
    logic        r_done, n_done;
    logic [23:0] r_pen_fg, n_pen_fg;
    logic [23:0] r_pen_bg, n_pen_bg;
    logic [4:0]  r_pen_attr, n_pen_attr;
    logic        r_valid, n_valid;
    t_cell       r_cell, n_cell;

    logic [9:0]  cols, rows;
    logic        accept, damaged;

    // Grid size saturated into its legal range.
    always_comb begin
        cols = (i_grid_cols == '0) ? 10'd1 :
               (i_grid_cols > MAX_GRID_DIM) ? MAX_GRID_DIM : i_grid_cols;
        rows = (i_grid_rows == '0) ? 10'd1 :
               (i_grid_rows > MAX_GRID_DIM) ? MAX_GRID_DIM : i_grid_rows;
    end

    assign accept      = i_cell.valid && i_en;
    assign i_cell.ready = i_en;

    assign damaged = (i_cell.back_glyph != i_cell.front_glyph) ||
                     (i_cell.back_fg != i_cell.front_fg) ||
                     (i_cell.back_bg != i_cell.front_bg) ||
                     (i_cell.back_attr != i_cell.front_attr);

    // Position, pen and damage decision for one accepted beat.
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_prev_dmg  = r_prev_dmg;
        n_pen_valid = r_pen_valid;
        n_done      = r_done;
        n_pen_fg    = r_pen_fg;
        n_pen_bg    = r_pen_bg;
        n_pen_attr  = r_pen_attr;
        n_valid     = 1'b0;
        n_cell      = r_cell;
        if (accept) begin
            if (i_cell.frame_start) begin
                n_col       = '0;
                n_row       = '0;
                n_prev_dmg  = 1'b0;
                n_pen_valid = 1'b0;
                n_done      = 1'b0;
            end
            if (!n_done) begin
                if (n_col >= cols) begin
                    n_col      = '0;
                    n_row      = n_row + 10'd1;
                    n_prev_dmg = 1'b0;
                end
                if (n_row >= rows) begin
                    n_done = 1'b1;
                end else begin
                    n_cell.cup   = !n_prev_dmg;
                    n_cell.sgr   = !n_pen_valid || (n_pen_fg != i_cell.back_fg) ||
                                   (n_pen_bg != i_cell.back_bg) ||
                                   (n_pen_attr != i_cell.back_attr);
                    n_cell.row1  = n_row + 10'd1;
                    n_cell.col1  = n_col + 10'd1;
                    n_cell.fg    = i_cell.back_fg;
                    n_cell.bg    = i_cell.back_bg;
                    n_cell.attr  = i_cell.back_attr;
                    n_cell.glyph = i_cell.back_glyph;
                    n_valid      = damaged;
                    if (damaged && n_cell.sgr) begin
                        n_pen_fg    = i_cell.back_fg;
                        n_pen_bg    = i_cell.back_bg;
                        n_pen_attr  = i_cell.back_attr;
                        n_pen_valid = 1'b1;
                    end
                    n_prev_dmg = damaged;
                    n_col      = n_col + 10'd1;
                    if (n_col >= cols) begin
                        n_col      = '0;
                        n_prev_dmg = 1'b0;
                        n_row      = n_row + 10'd1;
                        if (n_row >= rows) begin
                            n_done = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // State registers; the output stage moves only with the pipeline enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_prev_dmg  <= 1'b0;
            r_pen_valid <= 1'b0;
            r_done      <= 1'b1;
            r_valid     <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_prev_dmg  <= n_prev_dmg;
            r_pen_valid <= n_pen_valid;
            r_done      <= n_done;
            if (i_en) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pen_fg   <= n_pen_fg;
        r_pen_bg   <= n_pen_bg;
        r_pen_attr <= n_pen_attr;
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

`default_nettype wire

// ===== sv/tcde_color.sv =====
// Number pipeline: xterm-256 palette indices and decimal digits for one damaged cell.
// Depends on tcde_pkg.
`default_nettype none

module tcde_color (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tcde_pkg::t_cell i_cell,
    output logic            o_valid,
    output tcde_pkg::t_cmd  o_cmd
);
    import tcde_pkg::*;

    // Channels as [color][channel]: color 0 foreground, channel 2 red.
    typedef logic [1:0][2:0][7:0] t_chan;

    t_chan ch0, ch2, ch3;

    // Stage 1: cube levels, channel average, hundreds digits.
    logic                       r_v1;
    t_cell                      r_c1;
    logic [1:0][2:0][2:0]       r_lv1, n_lv1;
    logic [1:0][7:0]            r_avg1, n_avg1;
    t_hund [1:0][2:0]           r_chh1, n_chh1;
    t_hund                      r_rowh1, r_colh1;
    logic [1:0][9:0]            sum1;
    logic [1:0][21:0]           prod1;

    // Stage 2: cube distances per channel, grey step, final channel digits.
    logic                       r_v2;
    t_cell                      r_c2;
    logic [1:0][2:0][2:0]       r_lv2;
    logic [1:0][2:0][7:0]       r_dc2, n_dc2;
    logic [1:0][4:0]            r_step2, n_step2;
    t_dec3 [1:0][2:0]           r_chd2, n_chd2;
    t_dec3                      r_row2, r_col2, n_row2, n_col2;
    logic [1:0][15:0]           sprod2;

    // Stage 3: cube squared distance and grey channel distances.
    logic                       r_v3;
    t_cell                      r_c3;
    logic [1:0][2:0][2:0]       r_lv3;
    logic [1:0][4:0]            r_step3;
    t_dec3 [1:0][2:0]           r_chd3;
    t_dec3                      r_row3, r_col3;
    logic [1:0][17:0]           r_cd3, n_cd3;
    logic [1:0][2:0][7:0]       r_gd3, n_gd3;
    logic [1:0][7:0]            gv3;

    // Stage 4: palette index.
    logic                       r_v4;
    t_cell                      r_c4;
    t_dec3 [1:0][2:0]           r_chd4;
    t_dec3                      r_row4, r_col4;
    logic [1:0][7:0]            r_idx4, n_idx4;
    logic [1:0][17:0]           gdd4;

    // Stage 5: hundreds of the index.
    logic                       r_v5;
    t_cell                      r_c5;
    t_dec3 [1:0][2:0]           r_chd5;
    t_dec3                      r_row5, r_col5;
    t_hund [1:0]                r_idxh5;

    // Stage 6: finished command.
    logic                       r_v6;
    t_cmd                       r_cmd6, n_cmd6;

    assign ch0 = {i_cell.bg, i_cell.fg};
    assign ch2 = {r_c1.bg, r_c1.fg};
    assign ch3 = {r_c2.bg, r_c2.fg};

    // Stage 1 logic: average by a reciprocal multiply, exact for sums up to 765.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_lv1[c][k]  = nearest_level(ch0[c][k]);
                n_chh1[c][k] = dec_hund({2'b00, ch0[c][k]});
            end
            sum1[c]   = 10'(ch0[c][0]) + 10'(ch0[c][1]) + 10'(ch0[c][2]);
            prod1[c]  = 22'(sum1[c]) * 22'd2731;
            n_avg1[c] = prod1[c][20:13];
        end
    end

    // Stage 2 logic: grey step is (avg - 3) / 10 by reciprocal, capped at 23.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < 3; k++) begin
                n_dc2[c][k]    = abs_diff(ch2[c][k], cube_level(r_lv1[c][k]));
                n_chd2[c][k].h = r_chh1[c][k].h;
                {n_chd2[c][k].t, n_chd2[c][k].o} = dec_tens(r_chh1[c][k].r);
            end
            sprod2[c] = 16'(r_avg1[c] - 8'd3) * 16'd205;
            if (r_avg1[c] < 8'd3) begin
                n_step2[c] = '0;
            end else if (sprod2[c][15:11] > 5'd23) begin
                n_step2[c] = 5'd23;
            end else begin
                n_step2[c] = sprod2[c][15:11];
            end
        end
        n_row2.h = r_rowh1.h;
        {n_row2.t, n_row2.o} = dec_tens(r_rowh1.r);
        n_col2.h = r_colh1.h;
        {n_col2.t, n_col2.o} = dec_tens(r_colh1.r);
    end

    // Stage 3 logic: squared cube distance, grey level distances.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_cd3[c] = 18'(16'(r_dc2[c][0]) * 16'(r_dc2[c][0])) +
                       18'(16'(r_dc2[c][1]) * 16'(r_dc2[c][1])) +
                       18'(16'(r_dc2[c][2]) * 16'(r_dc2[c][2]));
            gv3[c]   = 8'(r_step2[c]) * 8'd10 + 8'd8;
            for (int k = 0; k < 3; k++) begin
                n_gd3[c][k] = abs_diff(ch3[c][k], gv3[c]);
            end
        end
    end

    // Stage 4 logic: the grey ramp wins only when strictly nearer.
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            gdd4[c] = 18'(16'(r_gd3[c][0]) * 16'(r_gd3[c][0])) +
                      18'(16'(r_gd3[c][1]) * 16'(r_gd3[c][1])) +
                      18'(16'(r_gd3[c][2]) * 16'(r_gd3[c][2]));
            if (gdd4[c] < r_cd3[c]) begin
                n_idx4[c] = GREY_BASE + 8'(r_step3[c]);
            end else begin
                n_idx4[c] = CUBE_BASE + 8'(r_lv3[c][2]) * 8'd36 +
                            8'(r_lv3[c][1]) * 8'd6 + 8'(r_lv3[c][0]);
            end
        end
    end

    // Stage 6 logic: assemble the command.
    always_comb begin
        n_cmd6.cup    = r_c5.cup;
        n_cmd6.sgr    = r_c5.sgr;
        n_cmd6.attr   = r_c5.attr;
        n_cmd6.glyph  = r_c5.glyph;
        n_cmd6.row    = r_row5;
        n_cmd6.col    = r_col5;
        n_cmd6.fg_rgb = r_chd5[0];
        n_cmd6.bg_rgb = r_chd5[1];
        n_cmd6.fg_idx.h = r_idxh5[0].h;
        {n_cmd6.fg_idx.t, n_cmd6.fg_idx.o} = dec_tens(r_idxh5[0].r);
        n_cmd6.bg_idx.h = r_idxh5[1].h;
        {n_cmd6.bg_idx.t, n_cmd6.bg_idx.o} = dec_tens(r_idxh5[1].r);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1    <= i_cell;
            r_lv1   <= n_lv1;
            r_avg1  <= n_avg1;
            r_chh1  <= n_chh1;
            r_rowh1 <= dec_hund(i_cell.row1);
            r_colh1 <= dec_hund(i_cell.col1);

            r_c2    <= r_c1;
            r_lv2   <= r_lv1;
            r_dc2   <= n_dc2;
            r_step2 <= n_step2;
            r_chd2  <= n_chd2;
            r_row2  <= n_row2;
            r_col2  <= n_col2;

            r_c3    <= r_c2;
            r_lv3   <= r_lv2;
            r_step3 <= r_step2;
            r_chd3  <= r_chd2;
            r_row3  <= r_row2;
            r_col3  <= r_col2;
            r_cd3   <= n_cd3;
            r_gd3   <= n_gd3;

            r_c4    <= r_c3;
            r_chd4  <= r_chd3;
            r_row4  <= r_row3;
            r_col4  <= r_col3;
            r_idx4  <= n_idx4;

            r_c5       <= r_c4;
            r_chd5     <= r_chd4;
            r_row5     <= r_row4;
            r_col5     <= r_col4;
            r_idxh5[0] <= dec_hund({2'b00, r_idx4[0]});
            r_idxh5[1] <= dec_hund({2'b00, r_idx4[1]});

            r_cmd6 <= n_cmd6;
        end
    end

    assign o_valid = r_v6;
    assign o_cmd   = r_cmd6;

endmodule

`default_nettype wire

// ===== sv/tcde_queue.sv =====
// Small command queue between the number pipeline and the byte serializer.
// Depends on tcde_pkg.
`default_nettype none

module tcde_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcde_pkg::t_cmd i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tcde_pkg::t_cmd o_data
);
    import tcde_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // A push never lands on a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");

    // A pop only takes an entry that is there.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== sv/tcde_back.sv =====
// Back end: turns one command into escape bytes and the UTF-8 glyph, one beat per ready cycle.
// Depends on tcde_pkg and tcde_byte_if.
`default_nettype none

module tcde_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_truecolor,
    input  logic           i_cmd_valid,
    input  tcde_pkg::t_cmd i_cmd,
    output logic           o_pop,
    tcde_byte_if.source    o_out
);
    import tcde_pkg::*;

    // Byte slots of one command; a slot is sent when its pending bit is set.
    localparam int NTOK      = 62;
    localparam int TOK_CUP   = 0;   // ESC [ row ; col H
    localparam int TOK_ROW   = 2;
    localparam int TOK_COL   = 6;
    localparam int TOK_HCMD  = 9;
    localparam int TOK_SGR   = 10;  // ESC [ 0
    localparam int TOK_ATTR  = 13;  // pairs of ; and code
    localparam int TOK_FGPRE = 23;  // ; 3 8 ; 2|5 ;
    localparam int TOK_FGN0  = 29;
    localparam int TOK_BGPRE = 40;
    localparam int TOK_BGN0  = 46;
    localparam int TOK_MCMD  = 57;
    localparam int TOK_GLY   = 58;

    typedef logic [NTOK-1:0] t_mask;

    t_cmd                 r_cmd;
    t_mask                r_pend, n_pend;
    logic [NTOK-1:0][7:0] tok;
    t_mask                load_mask;
    logic [5:0]           sel;
    logic                 out_acc, last, load;
    logic [1:0]           gl_len;
    logic [7:0]           mode_ch;

    // Digit enables with leading zeros dropped: bit 0 hundreds, bit 2 ones.
    function automatic logic [2:0] num_en(input t_dec3 d);
        return {1'b1, (d.h != '0) || (d.t != '0), d.h != '0};
    endfunction

    function automatic logic [7:0] dig(input t_digit d);
        return CH_ZERO + 8'(d);
    endfunction

    // UTF-8 length minus one; code points beyond the range take a single '?'.
    function automatic logic [1:0] utf8_len(input logic [20:0] c);
        logic [1:0] n;
        if (c < 21'h80)                 n = 2'd0;
        else if (c < 21'h800)           n = 2'd1;
        else if (c < 21'h10000)         n = 2'd2;
        else if (c <= MAX_CODE_POINT)   n = 2'd3;
        else                            n = 2'd0;
        return n;
    endfunction

    // Slots that a new command will send.
    always_comb begin
        load_mask = '0;
        if (i_cmd.cup) begin
            load_mask[TOK_CUP]     = 1'b1;
            load_mask[TOK_CUP + 1] = 1'b1;
            load_mask[TOK_ROW +: 3] = num_en(i_cmd.row);
            load_mask[TOK_ROW + 3] = 1'b1;
            load_mask[TOK_COL +: 3] = num_en(i_cmd.col);
            load_mask[TOK_HCMD]    = 1'b1;
        end
        if (i_cmd.sgr) begin
            load_mask[TOK_SGR +: 3] = 3'b111;
            for (int a = 0; a < 5; a++) begin
                load_mask[TOK_ATTR + 2 * a +: 2] = {2{i_cmd.attr[a]}};
            end
            load_mask[TOK_FGPRE +: 6] = 6'h3F;
            load_mask[TOK_BGPRE +: 6] = 6'h3F;
            load_mask[TOK_MCMD]       = 1'b1;
            if (i_truecolor) begin
                load_mask[TOK_FGN0 +: 3]     = num_en(i_cmd.fg_rgb[2]);
                load_mask[TOK_FGN0 + 3]      = 1'b1;
                load_mask[TOK_FGN0 + 4 +: 3] = num_en(i_cmd.fg_rgb[1]);
                load_mask[TOK_FGN0 + 7]      = 1'b1;
                load_mask[TOK_FGN0 + 8 +: 3] = num_en(i_cmd.fg_rgb[0]);
                load_mask[TOK_BGN0 +: 3]     = num_en(i_cmd.bg_rgb[2]);
                load_mask[TOK_BGN0 + 3]      = 1'b1;
                load_mask[TOK_BGN0 + 4 +: 3] = num_en(i_cmd.bg_rgb[1]);
                load_mask[TOK_BGN0 + 7]      = 1'b1;
                load_mask[TOK_BGN0 + 8 +: 3] = num_en(i_cmd.bg_rgb[0]);
            end else begin
                load_mask[TOK_FGN0 +: 3] = num_en(i_cmd.fg_idx);
                load_mask[TOK_BGN0 +: 3] = num_en(i_cmd.bg_idx);
            end
        end
        unique case (utf8_len(i_cmd.glyph))
            2'd0:    load_mask[TOK_GLY +: 4] = 4'b0001;
            2'd1:    load_mask[TOK_GLY +: 4] = 4'b0011;
            2'd2:    load_mask[TOK_GLY +: 4] = 4'b0111;
            default: load_mask[TOK_GLY +: 4] = 4'b1111;
        endcase
    end

    assign gl_len  = utf8_len(r_cmd.glyph);
    assign mode_ch = i_truecolor ? 8'h32 : 8'h35;

    // Byte value of every slot for the held command.
    always_comb begin
        tok = '0;
        tok[TOK_CUP]      = CH_ESC;
        tok[TOK_CUP + 1]  = CH_LBR;
        tok[TOK_ROW]      = dig(r_cmd.row.h);
        tok[TOK_ROW + 1]  = dig(r_cmd.row.t);
        tok[TOK_ROW + 2]  = dig(r_cmd.row.o);
        tok[TOK_ROW + 3]  = CH_SEMI;
        tok[TOK_COL]      = dig(r_cmd.col.h);
        tok[TOK_COL + 1]  = dig(r_cmd.col.t);
        tok[TOK_COL + 2]  = dig(r_cmd.col.o);
        tok[TOK_HCMD]     = CH_H;
        tok[TOK_SGR]      = CH_ESC;
        tok[TOK_SGR + 1]  = CH_LBR;
        tok[TOK_SGR + 2]  = CH_ZERO;
        for (int a = 0; a < 5; a++) begin
            tok[TOK_ATTR + 2 * a] = CH_SEMI;
        end
        tok[TOK_ATTR + 1] = 8'h31;
        tok[TOK_ATTR + 3] = 8'h32;
        tok[TOK_ATTR + 5] = 8'h33;
        tok[TOK_ATTR + 7] = 8'h34;
        tok[TOK_ATTR + 9] = 8'h37;
        tok[TOK_FGPRE]     = CH_SEMI;
        tok[TOK_FGPRE + 1] = 8'h33;
        tok[TOK_FGPRE + 2] = 8'h38;
        tok[TOK_FGPRE + 3] = CH_SEMI;
        tok[TOK_FGPRE + 4] = mode_ch;
        tok[TOK_FGPRE + 5] = CH_SEMI;
        tok[TOK_BGPRE]     = CH_SEMI;
        tok[TOK_BGPRE + 1] = 8'h34;
        tok[TOK_BGPRE + 2] = 8'h38;
        tok[TOK_BGPRE + 3] = CH_SEMI;
        tok[TOK_BGPRE + 4] = mode_ch;
        tok[TOK_BGPRE + 5] = CH_SEMI;
        for (int k = 0; k < 3; k++) begin
            tok[TOK_FGN0 + 4 * k]     = dig(i_truecolor ? r_cmd.fg_rgb[2 - k].h : r_cmd.fg_idx.h);
            tok[TOK_FGN0 + 4 * k + 1] = dig(i_truecolor ? r_cmd.fg_rgb[2 - k].t : r_cmd.fg_idx.t);
            tok[TOK_FGN0 + 4 * k + 2] = dig(i_truecolor ? r_cmd.fg_rgb[2 - k].o : r_cmd.fg_idx.o);
            tok[TOK_BGN0 + 4 * k]     = dig(i_truecolor ? r_cmd.bg_rgb[2 - k].h : r_cmd.bg_idx.h);
            tok[TOK_BGN0 + 4 * k + 1] = dig(i_truecolor ? r_cmd.bg_rgb[2 - k].t : r_cmd.bg_idx.t);
            tok[TOK_BGN0 + 4 * k + 2] = dig(i_truecolor ? r_cmd.bg_rgb[2 - k].o : r_cmd.bg_idx.o);
        end
        tok[TOK_FGN0 + 3]  = CH_SEMI;
        tok[TOK_FGN0 + 7]  = CH_SEMI;
        tok[TOK_BGN0 + 3]  = CH_SEMI;
        tok[TOK_BGN0 + 7]  = CH_SEMI;
        tok[TOK_MCMD]      = CH_M;

        // UTF-8 lead and continuation bytes.
        unique case (gl_len)
            2'd0: begin
                tok[TOK_GLY] = (r_cmd.glyph < 21'h80) ? {1'b0, r_cmd.glyph[6:0]} : CH_QUEST;
            end
            2'd1: begin
                tok[TOK_GLY]     = {3'b110, r_cmd.glyph[10:6]};
                tok[TOK_GLY + 1] = {2'b10, r_cmd.glyph[5:0]};
            end
            2'd2: begin
                tok[TOK_GLY]     = {4'b1110, r_cmd.glyph[15:12]};
                tok[TOK_GLY + 1] = {2'b10, r_cmd.glyph[11:6]};
                tok[TOK_GLY + 2] = {2'b10, r_cmd.glyph[5:0]};
            end
            default: begin
                tok[TOK_GLY]     = {5'b11110, r_cmd.glyph[20:18]};
                tok[TOK_GLY + 1] = {2'b10, r_cmd.glyph[17:12]};
                tok[TOK_GLY + 2] = {2'b10, r_cmd.glyph[11:6]};
                tok[TOK_GLY + 3] = {2'b10, r_cmd.glyph[5:0]};
            end
        endcase
    end

    // Lowest pending slot goes out next.
    always_comb begin
        sel = '0;
        for (int i = NTOK - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = 6'(i);
            end
        end
    end

    assign last    = ((r_pend & (r_pend - t_mask'(1))) == '0);
    assign out_acc = o_out.valid && o_out.ready;
    assign load    = i_cmd_valid && ((r_pend == '0) || (out_acc && last));
    assign o_pop   = load;

    always_comb begin
        n_pend = r_pend;
        if (out_acc) begin
            n_pend = r_pend & ~(t_mask'(1) << sel);
        end
        if (load) begin
            n_pend = load_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_out.valid    = (r_pend != '0);
    assign o_out.out_byte = tok[sel];
    assign o_out.run_last = last;

    // Once the last beat of a cell goes out with nothing waiting, the channel goes quiet.
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && last && !load) |=> !o_out.valid) else $error("bytes after run end");

    // Every command taken sends a glyph.
    a_glyph_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_pend[TOK_GLY]) else $error("command without glyph");

endmodule

`default_nettype wire

// ===== sv/terminal_cell_diff_encoder.sv =====
// Terminal cell-diff encoder. Takes one front/back cell pair per beat and emits the
// escape bytes that repaint the changed cells, one byte per beat. A clean cell
// causes no bytes; a damaged cell causes 1 to 62 bytes, and the one-byte output
// channel, sending one byte a cycle while the sink is ready, sets the sustained rate.
// Damaged cells pass a seven-stage classify and number pipeline (palette index and
// decimal digits) into a command queue, so input keeps flowing while bytes go out.
// Configuration is written through a plain write port and must only change while
// the block is idle.
`default_nettype none

module terminal_cell_diff_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [tcde_pkg::CFG_W-1:0] i_cfg_data,
    tcde_cell_if.sink                  i_cell,
    tcde_byte_if.source                o_out
);
    import tcde_pkg::*;

    logic [9:0] r_grid_cols;
    logic [9:0] r_grid_rows;
    logic       r_truecolor;

    logic  en, front_valid, color_valid, q_full, q_valid, q_pop, q_push;
    t_cell front_cell;
    t_cmd  color_cmd, q_cmd;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= 10'd80;
            r_grid_rows <= 10'd24;
            r_truecolor <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data[9:0];
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[9:0];
                CFG_TRUECOLOR: r_truecolor <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front pipeline holds while its finished command cannot enter the queue.
    assign en     = !(color_valid && q_full);
    assign q_push = color_valid && !q_full;

    tcde_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_cols (r_grid_cols),
        .i_grid_rows (r_grid_rows),
        .i_en        (en),
        .i_cell      (i_cell),
        .o_valid     (front_valid),
        .o_cell      (front_cell)
    );

    tcde_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_cell  (front_cell),
        .o_valid (color_valid),
        .o_cmd   (color_cmd)
    );

    tcde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (color_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    tcde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_truecolor (r_truecolor),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
